/* rtl/skv_pkg.sv */
// ----------------------------------------------------------------------------
// skv_pkg: shared types and constants of the sorted key/value table
// Sizes, operation and status codes, cell entry and command structs.
// ----------------------------------------------------------------------------
package skv_pkg;

  // Table sizing
  localparam int unsigned CAPACITY      = 16;
  localparam int unsigned MAX_KEY_BYTES = 8;
  localparam int unsigned VALUE_WIDTH   = 32;

  // Item field widths as seen on the ports
  localparam int unsigned REQ_W    = 4;
  localparam int unsigned KEY_IO_W = 64;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned VAL_IO_W = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned CNT_IO_W = 5;

  localparam int unsigned IN_DATA_W =
      ((KEY_IO_W + LEN_W + SLOT_W + VAL_IO_W + 7) / 8) * 8;
  localparam int unsigned RSP_W =
      STATUS_W + 1 + POS_W + VAL_IO_W + KEY_IO_W + LEN_W + CNT_IO_W;
  localparam int unsigned OUT_DATA_W = ((RSP_W + 7) / 8) * 8;

  // Internal widths
  localparam int unsigned KEY_W = 8 * MAX_KEY_BYTES;
  localparam int unsigned VAL_W = (VALUE_WIDTH < VAL_IO_W) ? VALUE_WIDTH : VAL_IO_W;
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [VAL_W-1:0]      val_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [KEY_IO_W-1:0]   io_key_t;
  typedef logic [VAL_IO_W-1:0]   io_val_t;
  typedef logic [POS_W-1:0]      io_pos_t;
  typedef logic [CNT_IO_W-1:0]   io_cnt_t;
  typedef logic [IN_DATA_W-1:0]  in_data_t;
  typedef logic [OUT_DATA_W-1:0] out_data_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT       = 4'd0,
    REQ_GET       = 4'd1,
    REQ_SET       = 4'd2,
    REQ_REMOVE    = 4'd3,
    REQ_CLEAR     = 4'd4,
    REQ_FIND      = 4'd5,
    REQ_READ_AT   = 4'd6,
    REQ_WRITE_AT  = 4'd7,
    REQ_REMOVE_AT = 4'd8,
    REQ_INSERT_AT = 4'd9
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_MISSING   = 3'd1,
    STATUS_PRESENT   = 3'd2,
    STATUS_BAD_INDEX = 3'd3,
    STATUS_FULL      = 3'd4
  } status_e;

  // Commands broadcast along the cell row
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_WRITE_VAL
  } cmd_op_e;

  typedef struct packed {
    key_t key;
    len_t len;
    val_t val;
  } entry_t;

  typedef struct packed {
    cmd_op_e op;
    cmp_t    addr;
    entry_t  ent;
  } cmd_t;

  typedef struct packed {
    logic load_new;
    logic load_val;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    io_key_t          key_bytes;
    len_t             key_length;
    logic [SLOT_W-1:0] slot_index;
    io_val_t          value_in;
  } req_t;

  typedef struct packed {
    status_e status;
    logic    found;
    io_pos_t position;
    io_val_t value_out;
    io_key_t key_out;
    len_t    key_length_out;
    io_cnt_t entry_count_out;
  } rsp_t;

endpackage

/* rtl/skv_cell.sv */
// ----------------------------------------------------------------------------
// skv_cell: one slot of the table row
// Holds one entry, shifts to/from its neighbors, compares against the key.
// ----------------------------------------------------------------------------
module skv_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  skv_pkg::cell_ctl_t ctl_i,
  input  skv_pkg::entry_t    new_i,
  input  skv_pkg::entry_t    left_i,
  input  skv_pkg::entry_t    right_i,
  output skv_pkg::entry_t    ent_o,
  output logic               less_o,
  output logic               greater_o
);

  skv_pkg::entry_t ent_q;
  logic            less_d, greater_d;
  logic            less_q, greater_q;

  always_ff @(posedge clk_i) begin
    priority if (ctl_i.load_new) begin
      ent_q <= new_i;
    end else if (ctl_i.load_val) begin
      ent_q.val <= new_i.val;
    end else if (ctl_i.take_left) begin
      ent_q <= left_i;
    end else if (ctl_i.take_right) begin
      ent_q <= right_i;
    end else begin
      ent_q <= ent_q;
    end
  end

  // order: length first, then key as an unsigned number
  always_comb begin
    less_d    = (ent_q.len < new_i.len) ||
                ((ent_q.len == new_i.len) && (ent_q.key < new_i.key));
    greater_d = (ent_q.len > new_i.len) ||
                ((ent_q.len == new_i.len) && (ent_q.key > new_i.key));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      less_q    <= 1'b0;
      greater_q <= 1'b0;
    end else begin
      less_q    <= less_d;
      greater_q <= greater_d;
    end
  end

  assign ent_o     = ent_q;
  assign less_o    = less_q;
  assign greater_o = greater_q;

endmodule

/* rtl/skv_seq.sv */
// ----------------------------------------------------------------------------
// skv_seq: request sequencer of the sorted key/value table
// Takes a request, runs the binary search over the cell flags for lookups,
// decides the result and issues one command to the cell row.
// ----------------------------------------------------------------------------
module skv_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  skv_pkg::req_t                 req_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output skv_pkg::rsp_t                 rsp_o,
  output skv_pkg::cmd_t                 cmd_o,
  input  skv_pkg::entry_t               rd_ent_i,
  input  logic [skv_pkg::CAPACITY-1:0]  less_i,
  input  logic [skv_pkg::CAPACITY-1:0]  greater_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMPARE,
    S_SEARCH,
    S_ACCESS,
    S_FINISH
  } state_e;

  state_e            state_q;
  skv_pkg::req_e     kind_q;
  skv_pkg::entry_t   ent_q;
  skv_pkg::entry_t   rd_q;
  skv_pkg::cmp_t     addr_q;
  skv_pkg::cnt_t     count_q, count_d;
  skv_pkg::cnt_t     hi_q, lo_q;
  logic              last_low_q, hit_q;
  logic              rsp_valid_q;
  skv_pkg::rsp_t     rsp_q, rsp_d;
  skv_pkg::cmd_op_e  op_d;

  skv_pkg::req_e     kind_in;
  skv_pkg::len_t     len_in;
  skv_pkg::key_t     key_in;
  logic              is_search;

  logic [skv_pkg::CNT_W:0] sum;
  skv_pkg::idx_t     guess;
  skv_pkg::cnt_t     guess_cnt;
  logic              out_free;
  logic              full;

  // incoming request: saturate the length, mask unused key bytes
  always_comb begin
    kind_in = skv_pkg::req_e'(req_i.req_type);
    len_in  = (req_i.key_length > skv_pkg::len_t'(skv_pkg::MAX_KEY_BYTES)) ?
              skv_pkg::len_t'(skv_pkg::MAX_KEY_BYTES) : req_i.key_length;
    key_in  = '0;
    for (int b = 0; b < int'(skv_pkg::MAX_KEY_BYTES); b++) begin
      if (b < int'(len_in)) begin
        key_in[8*b +: 8] = req_i.key_bytes[8*b +: 8];
      end
    end
    is_search = (kind_in == skv_pkg::REQ_PUT) || (kind_in == skv_pkg::REQ_GET) ||
                (kind_in == skv_pkg::REQ_SET) || (kind_in == skv_pkg::REQ_REMOVE) ||
                (kind_in == skv_pkg::REQ_FIND);
  end

  // probe point: (high + low) / 2, with low kept as low + 1
  always_comb begin
    sum       = {1'b0, hi_q} + {1'b0, lo_q} - 1'b1;
    guess     = sum[skv_pkg::IDX_W:1];
    guess_cnt = skv_pkg::cnt_t'(guess);
  end

  assign out_free = !rsp_valid_q || rsp_ready_i;
  assign full     = (count_q >= skv_pkg::cnt_t'(skv_pkg::CAPACITY));

  // result and table command
  always_comb begin
    rsp_d   = '0;
    op_d    = skv_pkg::CMD_HOLD;
    count_d = count_q;
    unique case (kind_q)
      skv_pkg::REQ_PUT: begin
        rsp_d.found    = hit_q;
        rsp_d.position = skv_pkg::io_pos_t'(addr_q);
        if (hit_q) begin
          rsp_d.status    = skv_pkg::STATUS_PRESENT;
          rsp_d.value_out = skv_pkg::io_val_t'(rd_q.val);
        end else if (full) begin
          rsp_d.status = skv_pkg::STATUS_FULL;
        end else begin
          op_d            = skv_pkg::CMD_INSERT;
          count_d         = count_q + 1'b1;
          rsp_d.value_out = skv_pkg::io_val_t'(ent_q.val);
        end
      end
      skv_pkg::REQ_GET: begin
        rsp_d.found    = hit_q;
        rsp_d.position = skv_pkg::io_pos_t'(addr_q);
        if (hit_q) begin
          rsp_d.value_out = skv_pkg::io_val_t'(rd_q.val);
        end else begin
          rsp_d.status    = skv_pkg::STATUS_MISSING;
          rsp_d.value_out = skv_pkg::io_val_t'(ent_q.val);
        end
      end
      skv_pkg::REQ_SET: begin
        rsp_d.found    = hit_q;
        rsp_d.position = skv_pkg::io_pos_t'(addr_q);
        if (hit_q) begin
          op_d            = skv_pkg::CMD_WRITE_VAL;
          rsp_d.value_out = skv_pkg::io_val_t'(ent_q.val);
        end else begin
          rsp_d.status = skv_pkg::STATUS_MISSING;
        end
      end
      skv_pkg::REQ_REMOVE: begin
        rsp_d.found    = hit_q;
        rsp_d.position = skv_pkg::io_pos_t'(addr_q);
        if (hit_q) begin
          op_d            = skv_pkg::CMD_REMOVE;
          count_d         = count_q - 1'b1;
          rsp_d.value_out = skv_pkg::io_val_t'(rd_q.val);
        end else begin
          rsp_d.status = skv_pkg::STATUS_MISSING;
        end
      end
      skv_pkg::REQ_FIND: begin
        rsp_d.found    = hit_q;
        rsp_d.position = skv_pkg::io_pos_t'(addr_q);
        if (!hit_q) begin
          rsp_d.status = skv_pkg::STATUS_MISSING;
        end
      end
      skv_pkg::REQ_CLEAR: begin
        count_d = '0;
      end
      skv_pkg::REQ_READ_AT, skv_pkg::REQ_WRITE_AT, skv_pkg::REQ_REMOVE_AT: begin
        rsp_d.position = skv_pkg::io_pos_t'(addr_q);
        if (addr_q >= skv_pkg::cmp_t'(count_q)) begin
          rsp_d.status = skv_pkg::STATUS_BAD_INDEX;
        end else begin
          rsp_d.key_out        = skv_pkg::io_key_t'(rd_q.key);
          rsp_d.key_length_out = rd_q.len;
          rsp_d.value_out      = skv_pkg::io_val_t'(rd_q.val);
          if (kind_q == skv_pkg::REQ_WRITE_AT) begin
            op_d            = skv_pkg::CMD_WRITE_VAL;
            rsp_d.value_out = skv_pkg::io_val_t'(ent_q.val);
          end
          if (kind_q == skv_pkg::REQ_REMOVE_AT) begin
            op_d    = skv_pkg::CMD_REMOVE;
            count_d = count_q - 1'b1;
          end
        end
      end
      skv_pkg::REQ_INSERT_AT: begin
        rsp_d.position = skv_pkg::io_pos_t'(addr_q);
        if (addr_q > skv_pkg::cmp_t'(count_q)) begin
          rsp_d.status = skv_pkg::STATUS_BAD_INDEX;
        end else if (full) begin
          rsp_d.status = skv_pkg::STATUS_FULL;
        end else begin
          op_d                 = skv_pkg::CMD_INSERT;
          count_d              = count_q + 1'b1;
          rsp_d.value_out      = skv_pkg::io_val_t'(ent_q.val);
          rsp_d.key_out        = skv_pkg::io_key_t'(ent_q.key);
          rsp_d.key_length_out = ent_q.len;
        end
      end
      default: begin
        // unknown request: no change
      end
    endcase
    rsp_d.entry_count_out = skv_pkg::io_cnt_t'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= skv_pkg::REQ_CLEAR;
      ent_q       <= '0;
      rd_q        <= '0;
      addr_q      <= '0;
      count_q     <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      last_low_q  <= 1'b1;
      hit_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      // a new result replaces one that leaves in the same cycle
      if ((state_q == S_FINISH) && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            kind_q     <= kind_in;
            ent_q.key  <= key_in;
            ent_q.len  <= len_in;
            ent_q.val  <= req_i.value_in[skv_pkg::VAL_W-1:0];
            addr_q     <= skv_pkg::cmp_t'(req_i.slot_index);
            hi_q       <= count_q;
            lo_q       <= '0;
            last_low_q <= 1'b1;
            hit_q      <= 1'b0;
            state_q    <= is_search ? S_COMPARE : S_ACCESS;
          end
        end
        S_COMPARE: begin
          // cells latch their compare flags against the new key
          state_q <= S_SEARCH;
        end
        S_SEARCH: begin
          if (hi_q <= lo_q) begin
            // miss: insertion point is just past the last probe that went low
            addr_q  <= skv_pkg::cmp_t'(last_low_q ? lo_q : hi_q);
            state_q <= S_ACCESS;
          end else if (less_i[guess]) begin
            lo_q       <= guess_cnt + 1'b1;
            last_low_q <= 1'b1;
          end else if (greater_i[guess]) begin
            hi_q       <= guess_cnt;
            last_low_q <= 1'b0;
          end else begin
            addr_q  <= skv_pkg::cmp_t'(guess_cnt);
            hit_q   <= 1'b1;
            state_q <= S_ACCESS;
          end
        end
        S_ACCESS: begin
          rd_q    <= rd_ent_i;
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            rsp_q   <= rsp_d;
            count_q <= count_d;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.op   = ((state_q == S_FINISH) && out_free) ? op_d : skv_pkg::CMD_HOLD;
    cmd_o.addr = addr_q;
    cmd_o.ent  = ent_q;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

/* rtl/sorted_key_value_table_unit.sv */
// ----------------------------------------------------------------------------
// sorted_key_value_table_unit: sorted key/value table with binary search
// A row of entry cells kept in order, searched by a sequencer, and shifted
// in place for inserts and removes.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel (tuser = operation code), one item
//   per request; each request gives exactly one result item on m_axis.
//   Entries are ordered by key length, then key value. Lookups (put, get,
//   set, remove, find) run a binary search: one probe per cycle over
//   compare flags that every cell computes in parallel against the key.
//   Index operations address a cell directly.
// Timing:
//   Lookups pass through the compare, search, access and finish states
//   from accept to result. Index operations, clear and unknown codes skip
//   compare and search. The next item is accepted the cycle after a result
//   is registered. Inserts and removes shift the whole row in the same
//   cycle that the result is registered.
// Reset:
//   The entry count clears to zero; cell contents stay undefined until
//   written. No clearing pass is needed.
// Stalls:
//   The result waits in an output register; a new item is still accepted
//   and worked on, and only its final step waits for the register to free.
// ----------------------------------------------------------------------------
module sorted_key_value_table_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // key_bytes[63:0], key_length[67:64], slot_index[72:68], value_in[104:73]
  input  skv_pkg::in_data_t          s_axis_tdata,
  // req_type[3:0]
  input  logic [skv_pkg::REQ_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // status[2:0], found[3], position[8:4], value_out[40:9], key_out[104:41],
  // key_length_out[108:105], entry_count_out[113:109]
  output skv_pkg::out_data_t         m_axis_tdata
);

  skv_pkg::req_t   req;
  skv_pkg::rsp_t   rsp;
  skv_pkg::cmd_t   cmd;
  skv_pkg::entry_t rd_ent;
  skv_pkg::entry_t ent [skv_pkg::CAPACITY];
  logic [skv_pkg::CAPACITY-1:0] less, greater;

  // unpack the request item
  always_comb begin
    req.req_type   = s_axis_tuser;
    req.key_bytes  = s_axis_tdata[63:0];
    req.key_length = s_axis_tdata[67:64];
    req.slot_index = s_axis_tdata[72:68];
    req.value_in   = s_axis_tdata[104:73];
  end

  skv_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .rsp_valid_o (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .rsp_o       (rsp),
    .cmd_o       (cmd),
    .rd_ent_i    (rd_ent),
    .less_i      (less),
    .greater_i   (greater)
  );

  // cell row: cell i sits at table index i
  for (genvar i = 0; i < skv_pkg::CAPACITY; i++) begin : g_cell
    skv_pkg::entry_t    left_ent, right_ent;
    skv_pkg::cell_ctl_t ctl;

    if (i == 0) begin : g_first
      assign left_ent = cmd.ent;
    end else begin : g_inner_l
      assign left_ent = ent[i-1];
    end

    if (i == skv_pkg::CAPACITY - 1) begin : g_last
      assign right_ent = ent[i];
    end else begin : g_inner_r
      assign right_ent = ent[i+1];
    end

    // insert: target loads, cells above shift up; remove: target and above
    // take from the right
    always_comb begin
      ctl = '0;
      unique case (cmd.op)
        skv_pkg::CMD_HOLD: begin
        end
        skv_pkg::CMD_INSERT: begin
          ctl.load_new  = (cmd.addr == skv_pkg::cmp_t'(i));
          ctl.take_left = (cmd.addr <  skv_pkg::cmp_t'(i));
        end
        skv_pkg::CMD_REMOVE: begin
          ctl.take_right = (cmd.addr <= skv_pkg::cmp_t'(i));
        end
        skv_pkg::CMD_WRITE_VAL: begin
          ctl.load_val = (cmd.addr == skv_pkg::cmp_t'(i));
        end
        default: begin
        end
      endcase
    end

    skv_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .new_i     (cmd.ent),
      .left_i    (left_ent),
      .right_i   (right_ent),
      .ent_o     (ent[i]),
      .less_o    (less[i]),
      .greater_o (greater[i])
    );
  end

  // single read port at the command address; registered in the sequencer
  always_comb begin
    rd_ent = '0;
    for (int i = 0; i < int'(skv_pkg::CAPACITY); i++) begin
      if (cmd.addr == skv_pkg::cmp_t'(i)) begin
        rd_ent = ent[i];
      end
    end
  end

  // pack the result item, first field lowest
  assign m_axis_tdata = skv_pkg::out_data_t'({rsp.entry_count_out, rsp.key_length_out,
                                              rsp.key_out, rsp.value_out, rsp.position,
                                              rsp.found, rsp.status});

endmodule

/* rtl/skv_checker.sv */
// ----------------------------------------------------------------------------
// skv_checker: port-level checks of the sorted key/value table
// Watches the top level's channels; attached by bind.
// ----------------------------------------------------------------------------
module skv_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input skv_pkg::in_data_t         s_axis_tdata,
  input logic [skv_pkg::REQ_W-1:0] s_axis_tuser,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input skv_pkg::out_data_t        m_axis_tdata
);

  // no result while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // one item at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
      s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item accepted while busy");

  // table full is only reported at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && (m_axis_tdata[2:0] == skv_pkg::STATUS_FULL) |->
      (m_axis_tdata[113:109] == skv_pkg::io_cnt_t'(skv_pkg::CAPACITY)))
    else $error("full status below capacity");

  // a hit never reports a miss or a bad index
  a_found_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && m_axis_tdata[3] |->
      (m_axis_tdata[2:0] != skv_pkg::STATUS_MISSING) &&
      (m_axis_tdata[2:0] != skv_pkg::STATUS_BAD_INDEX))
    else $error("found set with miss status");

endmodule

bind sorted_key_value_table_unit skv_checker u_skv_checker (.*);

/* dv/sorted_key_value_table_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_table_unit_tb: self-checking bench for the sorted table
// Drives lookup, index, clear and unknown-code requests over the request
// stream, predicts each response with a behavioral copy of the table, and
// checks every response field in order. Sender and receiver idle at random,
// and the receiver also holds off for one long stretch.
// ----------------------------------------------------------------------------
module sorted_key_value_table_unit_tb;

  localparam int ITEMS       = 600;
  localparam int POOL        = 24;
  localparam int BURST       = 20;
  localparam int LONG_STALL  = 400;
  localparam int DRAIN_WAIT  = 30;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [skv_pkg::REQ_W-1:0] REQ_TOP = '1;  // highest (unused) code

  typedef struct {
    logic [skv_pkg::REQ_W-1:0]  req;
    logic [63:0]                key;
    logic [skv_pkg::LEN_W-1:0]  len;
    logic [skv_pkg::SLOT_W-1:0] slot;
    logic [31:0]                val;
    bit                         drain;  // hold this item until all responses are back
  } tbl_req_t;

  typedef struct {
    logic [skv_pkg::STATUS_W-1:0] status;
    logic                         found;
    logic [skv_pkg::POS_W-1:0]    pos;
    logic [31:0]                  vout;
    logic [63:0]                  kout;
    logic [skv_pkg::LEN_W-1:0]    klen;
    logic [skv_pkg::CNT_IO_W-1:0] cnt;
  } tbl_rsp_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  skv_pkg::in_data_t          s_axis_tdata = '0;
  logic [skv_pkg::REQ_W-1:0]  s_axis_tuser = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  skv_pkg::out_data_t         m_axis_tdata;

  sorted_key_value_table_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Shadow table
  logic [63:0]               tbl_key [skv_pkg::CAPACITY];
  logic [skv_pkg::LEN_W-1:0] tbl_len [skv_pkg::CAPACITY];
  logic [31:0]               tbl_val [skv_pkg::CAPACITY];
  int                        tbl_count = 0;

  tbl_req_t req_pending[$];
  tbl_rsp_t rsp_expected[$];
  tbl_req_t in_flight;
  int       reqs_accepted = 0;
  int       results_seen = 0;   // updated with <= so other processes see it race-free
  int       total_items = 0;
  int       idle_phase = 0;
  int       mismatches = 0;
  logic [63:0]               pool_key [POOL];
  logic [skv_pkg::LEN_W-1:0] pool_len [POOL];

  function automatic int idle_pct(bit rx_side, int ph);
    case (ph)
      0:       return rx_side ? 61 : 25;
      1:       return rx_side ? 25 : 61;
      default: return 0;
    endcase
  endfunction

  // Binary search over the occupied entries; same probe order as the block.
  function automatic bit table_search(input logic [63:0] k, input int l, output int pos);
    int hi;
    int lo;
    int g;
    bit hit;
    hi  = tbl_count;
    lo  = -1;
    g   = -1;
    hit = 1'b0;
    while (!hit && (hi - lo > 1)) begin
      g = (hi + lo) / 2;
      if (int'(tbl_len[g]) < l) lo = g;
      else if (int'(tbl_len[g]) > l) hi = g;
      else if (tbl_key[g] < k) lo = g;
      else if (tbl_key[g] > k) hi = g;
      else hit = 1'b1;
    end
    if (!hit && g == lo) g++;
    pos = g;
    return hit;
  endfunction

  function automatic void table_insert(int at, logic [63:0] k, int l, logic [31:0] v);
    for (int i = tbl_count; i > at; i--) begin
      tbl_key[i] = tbl_key[i-1];
      tbl_len[i] = tbl_len[i-1];
      tbl_val[i] = tbl_val[i-1];
    end
    tbl_key[at] = k;
    tbl_len[at] = skv_pkg::len_t'(l);
    tbl_val[at] = v;
    tbl_count++;
  endfunction

  function automatic void table_delete(int at);
    for (int i = at; i + 1 < tbl_count; i++) begin
      tbl_key[i] = tbl_key[i+1];
      tbl_len[i] = tbl_len[i+1];
      tbl_val[i] = tbl_val[i+1];
    end
    tbl_count--;
  endfunction

  // Applies one request to the shadow table and returns the response it gives.
  function automatic tbl_rsp_t predict_table_op(tbl_req_t r);
    tbl_rsp_t e;
    int l;
    int pos;
    int idx;
    bit hit;
    logic [63:0] k;
    e   = '{default: 0};
    l   = (int'(r.len) > int'(skv_pkg::MAX_KEY_BYTES)) ?
          int'(skv_pkg::MAX_KEY_BYTES) : int'(r.len);  // long keys saturate
    k   = (l >= 8) ? {64{1'b1}} : ((64'd1 << (8 * l)) - 64'd1);
    k   = r.key & k;
    idx = int'(r.slot);
    e.status = skv_pkg::STATUS_OK;
    if (r.req <= skv_pkg::REQ_REMOVE || r.req == skv_pkg::REQ_FIND) begin
      hit     = table_search(k, l, pos);
      e.found = hit;
      e.pos   = skv_pkg::io_pos_t'(pos);
      case (r.req)
        skv_pkg::REQ_PUT: begin
          if (hit) begin
            e.status = skv_pkg::STATUS_PRESENT;
            e.vout   = tbl_val[pos];
          end else if (tbl_count >= skv_pkg::CAPACITY) begin
            e.status = skv_pkg::STATUS_FULL;
          end else begin
            table_insert(pos, k, l, r.val);
            e.vout = r.val;
          end
        end
        skv_pkg::REQ_GET: begin
          if (hit) begin
            e.vout = tbl_val[pos];
          end else begin
            e.status = skv_pkg::STATUS_MISSING;
            e.vout   = r.val;  // default on a miss
          end
        end
        skv_pkg::REQ_SET: begin
          if (hit) begin
            tbl_val[pos] = r.val;
            e.vout       = r.val;
          end else begin
            e.status = skv_pkg::STATUS_MISSING;
          end
        end
        skv_pkg::REQ_REMOVE: begin
          if (hit) begin
            e.vout = tbl_val[pos];
            table_delete(pos);
          end else begin
            e.status = skv_pkg::STATUS_MISSING;
          end
        end
        default: begin
          if (!hit) e.status = skv_pkg::STATUS_MISSING;
        end
      endcase
    end else if (r.req == skv_pkg::REQ_CLEAR) begin
      tbl_count = 0;
    end else if (r.req >= skv_pkg::REQ_READ_AT && r.req <= skv_pkg::REQ_REMOVE_AT) begin
      e.pos = r.slot;
      if (idx >= tbl_count) begin
        e.status = skv_pkg::STATUS_BAD_INDEX;
      end else begin
        if (r.req == skv_pkg::REQ_WRITE_AT) tbl_val[idx] = r.val;
        e.vout = tbl_val[idx];
        e.kout = tbl_key[idx];
        e.klen = tbl_len[idx];
        if (r.req == skv_pkg::REQ_REMOVE_AT) table_delete(idx);
      end
    end else if (r.req == skv_pkg::REQ_INSERT_AT) begin
      // placed where told, order and duplicates unchecked
      e.pos = r.slot;
      if (idx > tbl_count) begin
        e.status = skv_pkg::STATUS_BAD_INDEX;
      end else if (tbl_count >= skv_pkg::CAPACITY) begin
        e.status = skv_pkg::STATUS_FULL;
      end else begin
        table_insert(idx, k, l, r.val);
        e.vout = r.val;
        e.kout = k;
        e.klen = skv_pkg::len_t'(l);
      end
    end
    // unknown codes leave everything at zero but the count
    e.cnt = skv_pkg::io_cnt_t'(tbl_count);
    return e;
  endfunction

  task automatic add_req(logic [skv_pkg::REQ_W-1:0] op, logic [63:0] k,
                         logic [skv_pkg::LEN_W-1:0] l, logic [skv_pkg::SLOT_W-1:0] s,
                         logic [31:0] v);
    tbl_req_t r;
    r.req   = op;
    r.key   = k;
    r.len   = l;
    r.slot  = s;
    r.val   = v;
    r.drain = 1'b0;
    req_pending.push_back(r);
  endtask

  task automatic add_random_req();
    int pick;
    int p;
    int code;
    int sl;
    logic [skv_pkg::REQ_W-1:0]  op;
    logic [63:0]                k;
    logic [skv_pkg::LEN_W-1:0]  l;
    logic [skv_pkg::SLOT_W-1:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 34)      op = skv_pkg::REQ_PUT;
    else if (pick < 46) op = skv_pkg::REQ_GET;
    else if (pick < 54) op = skv_pkg::REQ_SET;
    else if (pick < 64) op = skv_pkg::REQ_REMOVE;
    else if (pick < 73) op = skv_pkg::REQ_FIND;
    else if (pick < 79) op = skv_pkg::REQ_READ_AT;
    else if (pick < 84) op = skv_pkg::REQ_WRITE_AT;
    else if (pick < 89) op = skv_pkg::REQ_REMOVE_AT;
    else if (pick < 94) op = skv_pkg::REQ_INSERT_AT;
    else if (pick < 96) op = skv_pkg::REQ_CLEAR;
    else begin
      code = $urandom_range(int'(skv_pkg::REQ_INSERT_AT) + 1, int'(REQ_TOP));
      op   = code[skv_pkg::REQ_W-1:0];
    end
    // mostly pool keys so lookups hit
    if ($urandom_range(0, 99) < 85) begin
      p = $urandom_range(0, POOL - 1);
      k = pool_key[p];
      l = pool_len[p];
    end else begin
      k = {$urandom, $urandom};
      l = skv_pkg::len_t'($urandom_range(0, 15));
    end
    sl = ($urandom_range(0, 99) < 85) ? $urandom_range(0, skv_pkg::CAPACITY) :
                                        $urandom_range(0, 31);
    s  = sl[skv_pkg::SLOT_W-1:0];
    add_req(op, k, l, s, $urandom);
  endtask

  // Request driver
  always @(posedge clk_i) begin : drive_proc
    bit take;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        rsp_expected.push_back(predict_table_op(in_flight));
        reqs_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        take = (req_pending.size() > 0) && ($urandom_range(0, 99) >= idle_pct(1'b0, idle_phase));
        if (take && req_pending[0].drain && reqs_accepted != results_seen) take = 1'b0;
        if (take) begin
          in_flight     = req_pending.pop_front();
          s_axis_tdata  <= skv_pkg::in_data_t'({in_flight.val, in_flight.slot, in_flight.len,
                                                in_flight.key});
          s_axis_tuser  <= in_flight.req;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      idle_phase <= (reqs_accepted * 3 < total_items) ? 0 :
                    (reqs_accepted * 3 < total_items * 2) ? 1 : 2;
    end
  end

  // Response ready, with one long hold-off late in the run
  always @(posedge clk_i) begin : ready_proc
    int  stall_left;
    bit  stall_done;
    if (!rst_ni) begin
      stall_left = 0;
      stall_done = 1'b0;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!stall_done && results_seen >= (total_items * 2) / 3 + 20) begin
      stall_done = 1'b1;
      stall_left = LONG_STALL;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1, idle_phase));
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Response checker
  always @(posedge clk_i) begin : check_proc
    tbl_rsp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rsp_expected.size() == 0) begin
        $display("%0t: unexpected response: expected none, actual %0h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = rsp_expected.pop_front();
        check_field("status",          64'(want.status), 64'(m_axis_tdata[2:0]));
        check_field("found",           64'(want.found),  64'(m_axis_tdata[3]));
        check_field("position",        64'(want.pos),    64'(m_axis_tdata[8:4]));
        check_field("value_out",       64'(want.vout),   64'(m_axis_tdata[40:9]));
        check_field("key_out",         want.kout,        m_axis_tdata[104:41]);
        check_field("key_length_out",  64'(want.klen),   64'(m_axis_tdata[108:105]));
        check_field("entry_count_out", 64'(want.cnt),    64'(m_axis_tdata[113:109]));
      end
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("sorted_key_value_table_unit_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    int base;
    int sl;
    for (int i = 0; i < POOL; i++) begin
      pool_key[i] = {$urandom, $urandom};
      pool_len[i] = (i == 0) ? '0 : skv_pkg::len_t'($urandom_range(1, 15));
    end

    // Directed: empty table, key extremes, every operation, odd cases
    add_req(skv_pkg::REQ_FIND,      64'h0000_0000_00AB_CDEF, 3, 0, 0);
    add_req(skv_pkg::REQ_READ_AT,   '0, 0, 0, 0);                          // index past end
    add_req(skv_pkg::REQ_INSERT_AT, 64'h1, 1, 1, 1);                       // index past end
    add_req(skv_pkg::REQ_PUT,       {64{1'b1}}, 0, 0, 32'h0);              // empty key
    add_req(skv_pkg::REQ_PUT,       {64{1'b1}}, 8, 0, 32'hFFFF_FFFF);
    add_req(skv_pkg::REQ_PUT,       64'h0123_4567_89AB_CDEF, 15, 31, 32'h1);  // long key
    add_req(skv_pkg::REQ_PUT,       64'hDEAD_BEEF_00AB_CDEF, 3, 0, 32'h5);
    add_req(skv_pkg::REQ_PUT,       64'h1111_1111_11AB_CDEF, 3, 0, 32'h6);    // already there
    add_req(skv_pkg::REQ_PUT,       64'h0, 1, 0, 32'h7);
    add_req(skv_pkg::REQ_PUT,       64'hFF, 1, 0, 32'h8);
    add_req(skv_pkg::REQ_GET,       64'hAB_CDEF, 3, 0, 32'h9);
    add_req(skv_pkg::REQ_GET,       64'h1234, 2, 0, 32'hCAFE_F00D);        // default back
    add_req(skv_pkg::REQ_SET,       {64{1'b1}}, 8, 0, 32'h0);
    add_req(skv_pkg::REQ_SET,       64'h55, 1, 0, 32'h3);
    add_req(skv_pkg::REQ_FIND,      64'hFF, 1, 0, 0);
    add_req(skv_pkg::REQ_REMOVE,    64'h0, 1, 0, 0);
    add_req(skv_pkg::REQ_REMOVE,    64'h0, 1, 0, 0);
    add_req(skv_pkg::REQ_READ_AT,   '0, 0, 0, 0);
    add_req(skv_pkg::REQ_WRITE_AT,  '0, 0, 1, 32'hAAAA_5555);
    add_req(skv_pkg::REQ_READ_AT,   '0, 0, 31, 0);
    add_req(skv_pkg::REQ_REMOVE_AT, '0, 0, 0, 0);
    add_req(skv_pkg::REQ_INSERT_AT, 64'hFFFF_1234, 2, 0, 32'h1234_5678);   // breaks order
    add_req(skv_pkg::REQ_INSERT_AT, 64'h0, 0, 31, 0);
    add_req(skv_pkg::REQ_FIND,      64'hFF, 1, 0, 0);
    add_req(REQ_TOP,                {64{1'b1}}, 15, 31, 32'hFFFF_FFFF);    // unknown code
    add_req(skv_pkg::REQ_CLEAR,     '0, 0, 0, 0);
    add_req(skv_pkg::REQ_GET,       64'hFF, 1, 0, 32'h42);

    // Random: a fill burst first (after a full drain), then a mix with more bursts
    base = $urandom_range(0, POOL - 1);
    for (int i = 0; i < BURST; i++)
      add_req(skv_pkg::REQ_PUT, pool_key[(base + i) % POOL], pool_len[(base + i) % POOL],
              0, $urandom);
    req_pending[req_pending.size() - BURST].drain = 1'b1;
    while (req_pending.size() < ITEMS) begin
      if ($urandom_range(0, 199) < 3) begin
        base = $urandom_range(0, POOL - 1);
        for (int i = 0; i < BURST; i++) begin
          sl = $urandom_range(0, 31);
          add_req(skv_pkg::REQ_PUT, pool_key[(base + i) % POOL], pool_len[(base + i) % POOL],
                  sl[skv_pkg::SLOT_W-1:0], $urandom);
        end
      end else begin
        add_random_req();
      end
    end
    req_pending[ITEMS / 2].drain = 1'b1;
    total_items = req_pending.size();

    // assert reset ahead of the first clock edge so the block sees the edge
    #1 rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_pending.size() > 0 || s_axis_tvalid || rsp_expected.size() > 0)
      @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("sorted_key_value_table_unit_tb: PASS");
    end else begin
      $display("sorted_key_value_table_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
